// File: design/stirling_number_engine_macros.svh
`ifndef STIRLING_NUMBER_ENGINE_MACROS_SVH
`define STIRLING_NUMBER_ENGINE_MACROS_SVH

// overlapping implication, checked on every rising edge outside reset
`define SNE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sne_pkg.sv
`default_nettype none

package sne_pkg;

	localparam int IDX_W = 5;
	localparam int VAL_W = 64;
	localparam int MUL_W = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ROW,
		ST_READ,
		ST_MUL,
		ST_ADD,
		ST_FETCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_query;
		logic start_row;
		logic issue_read;
		logic do_mul;
		logic do_add;
		logic issue_fetch;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic too_big;
		logic k_above_n;
		logic n_zero;
		logic col_done;
		logic row_done;
		logic ovf_now;
		logic out_ready;
	} sts_t;

endpackage

`default_nettype wire

// File: design/sne_datapath.sv
`default_nettype none

module sne_datapath #(
	parameter int MAX_N = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sne_pkg::cmd_t                 cmd,
	output sne_pkg::sts_t                      sts,
	input  wire logic                          kind,
	input  wire logic [sne_pkg::IDX_W-1:0]     row_index,
	input  wire logic [sne_pkg::IDX_W-1:0]     column_index,
	input  wire logic                          result_stall,
	output logic                               result_valid,
	output logic signed [sne_pkg::VAL_W-1:0]   value,
	output logic                               overflow
);

	import sne_pkg::*;

	localparam int Depth = MAX_N + 1;
	localparam int AW = $clog2(Depth);
	localparam logic [IDX_W-1:0] MaxN = IDX_W'(MAX_N);

	// query registers
	logic             kind_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] k_q;

	// row and column counters of the band sweep
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] lo_q;
	logic             ovf_flag_q;

	// row store and its valid bits
	logic signed [VAL_W-1:0] mem [Depth];
	logic [Depth-1:0]        valid_q;
	logic signed [VAL_W-1:0] rdata_a_q;
	logic signed [VAL_W-1:0] rdata_b_q;
	logic                    rvalid_a_q;
	logic                    rvalid_b_q;
	logic                    left_en_q;

	// multiply stage
	logic signed [VAL_W-1:0] prod_q;
	logic                    mul_ovf_q;

	// output register
	logic                    result_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    overflow_q;

	logic [IDX_W-1:0]          i_nx;
	logic [IDX_W-1:0]          hi;
	logic [IDX_W:0]            ksum;
	logic [IDX_W-1:0]          lo;
	logic [AW-1:0]             addr_a;
	logic [AW-1:0]             addr_b;
	logic [IDX_W-1:0]          j_m1;
	logic [IDX_W-1:0]          i_m1;
	logic signed [MUL_W-1:0]   mult;
	logic signed [VAL_W-1:0]   a_eff;
	logic signed [VAL_W-1:0]   b_eff;
	logic signed [VAL_W+MUL_W-1:0] prod_full;
	logic                      prod_ovf;
	logic [VAL_W:0]            sum;
	logic                      add_ovf;
	logic                      too_big;
	logic                      out_ready;

	// band limits of the next row
	always_comb begin
		i_nx = i_q + IDX_W'(1);
		hi   = (i_nx < k_q) ? i_nx : k_q;
		ksum = {1'b0, k_q} + {1'b0, i_nx};
		lo   = (ksum > {1'b0, n_q}) ? IDX_W'(ksum - {1'b0, n_q}) : '0;
	end

	// read addresses
	assign j_m1   = j_q - IDX_W'(1);
	assign addr_a = cmd.issue_fetch ? k_q[AW-1:0] : j_q[AW-1:0];
	assign addr_b = j_m1[AW-1:0];

	// multiplier operand and product with range check
	assign i_m1      = i_q - IDX_W'(1);
	assign mult      = kind_q ? $signed({2'b00, j_q}) : -$signed({2'b00, i_m1});
	assign a_eff     = rvalid_a_q ? rdata_a_q : '0;
	assign prod_full = (VAL_W+MUL_W)'(a_eff) * (VAL_W+MUL_W)'(mult);
	assign prod_ovf  = prod_full[VAL_W+MUL_W-1:VAL_W-1] != {(MUL_W+1){prod_full[VAL_W-1]}};

	// add of left neighbor with range check
	assign b_eff   = (left_en_q && rvalid_b_q) ? rdata_b_q : '0;
	assign sum     = {prod_q[VAL_W-1], prod_q} + {b_eff[VAL_W-1], b_eff};
	assign add_ovf = sum[VAL_W] != sum[VAL_W-1];

	assign too_big   = n_q > MaxN;
	assign out_ready = !result_valid_q || !result_stall;

	// status toward the controller
	always_comb begin
		sts.too_big   = too_big;
		sts.k_above_n = k_q > n_q;
		sts.n_zero    = n_q == '0;
		sts.col_done  = j_q == lo_q;
		sts.row_done  = i_q == n_q;
		sts.ovf_now   = mul_ovf_q || add_ovf;
		sts.out_ready = out_ready;
	end

	// query capture
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			kind_q <= kind;
			n_q    <= row_index;
			k_q    <= column_index;
		end
	end

	// counters and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			lo_q       <= '0;
			ovf_flag_q <= 1'b0;
		end else if (cmd.load_query) begin
			i_q        <= '0;
			j_q        <= '0;
			lo_q       <= '0;
			ovf_flag_q <= 1'b0;
		end else if (cmd.start_row) begin
			i_q  <= i_nx;
			j_q  <= hi;
			lo_q <= lo;
		end else if (cmd.do_add) begin
			ovf_flag_q <= mul_ovf_q || add_ovf;
			if (j_q != lo_q) begin
				j_q <= j_m1;
			end
		end
	end

	// valid bits: only entry zero holds a value at the start of a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.load_query) begin
			valid_q <= Depth'(1);
		end else if (cmd.do_add) begin
			valid_q[j_q[AW-1:0]] <= 1'b1;
		end
	end

	// row store write port
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			mem[AW'(0)] <= VAL_W'(1);
		end else if (cmd.do_add) begin
			mem[j_q[AW-1:0]] <= sum[VAL_W-1:0];
		end
	end

	// row store read ports, registered
	always_ff @(posedge clk) begin
		if (cmd.issue_read || cmd.issue_fetch) begin
			rdata_a_q  <= mem[addr_a];
			rvalid_a_q <= valid_q[addr_a];
		end
		if (cmd.issue_read) begin
			rdata_b_q  <= mem[addr_b];
			rvalid_b_q <= valid_q[addr_b];
			left_en_q  <= j_q != '0;
		end
	end

	// multiply stage register
	always_ff @(posedge clk) begin
		if (cmd.do_mul) begin
			prod_q    <= prod_full[VAL_W-1:0];
			mul_ovf_q <= prod_ovf;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			value_q    <= (too_big || sts.k_above_n || ovf_flag_q) ? '0 : a_eff;
			overflow_q <= too_big || ovf_flag_q;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

// File: design/sne_ctrl.sv
`default_nettype none

module sne_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          query_valid,
	input  wire sne_pkg::sts_t sts,
	output sne_pkg::cmd_t      cmd,
	output logic               idle
);

	import sne_pkg::*;

	state_t state_q;
	state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_valid) begin
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (sts.too_big || sts.k_above_n) begin
					state_nx = ST_DONE;
				end else if (sts.n_zero) begin
					state_nx = ST_FETCH;
				end else begin
					state_nx = ST_ROW;
				end
			end
			ST_ROW:  state_nx = ST_READ;
			ST_READ: state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_ADD;
			ST_ADD: begin
				priority if (sts.ovf_now) begin
					state_nx = ST_DONE;
				end else if (!sts.col_done) begin
					state_nx = ST_READ;
				end else if (!sts.row_done) begin
					state_nx = ST_ROW;
				end else begin
					state_nx = ST_FETCH;
				end
			end
			ST_FETCH: state_nx = ST_DONE;
			ST_DONE: begin
				if (sts.out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.load_query  = (state_q == ST_IDLE) && query_valid;
		cmd.start_row   = state_q == ST_ROW;
		cmd.issue_read  = state_q == ST_READ;
		cmd.do_mul      = state_q == ST_MUL;
		cmd.do_add      = state_q == ST_ADD;
		cmd.issue_fetch = state_q == ST_FETCH;
		cmd.load_result = (state_q == ST_DONE) && sts.out_ready;
	end

	assign idle = state_q == ST_IDLE;

endmodule

`default_nettype wire

// File: design/stirling_number_engine.sv
`default_nettype none

// Stirling number engine: answers one query (kind, n, k) with one 64-bit signed
// number, s(n,k) of the first kind when kind is 0, S(n,k) of the second kind
// when kind is 1.
// Query channel: a beat moves when query_valid is high and query_stall low.
// query_stall is high from the cycle after a beat until the result has been
// placed in the output register, so one query is in flight at a time.
// Result channel: a beat moves when result_valid is high and result_stall low;
// value and overflow hold while stalled. The output register lets a new query
// be taken while the previous result still waits.
// Sequence: the band that feeds (n,k) is swept row by row through a row store
// with one shared multiplier; each cell steps through read, multiply, then add
// and write, each row adds a row start, and each query adds index check, final
// fetch and output load. n above MAX_N or k above n go from the index check
// straight to the output load. The next query can be taken in the cycle after
// the result is loaded; a stalled result still in the register holds back that
// load.
// overflow is set, with value zero, when n exceeds MAX_N or a cell leaves the
// signed 64-bit range; the sweep stops at the first such cell.
// Reset (arst_n low) empties the output register and returns to idle.

module stirling_number_engine #(
	parameter int MAX_N = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          query_valid,
	output logic                               query_stall,
	input  wire logic                          kind,
	input  wire logic [sne_pkg::IDX_W-1:0]     row_index,
	input  wire logic [sne_pkg::IDX_W-1:0]     column_index,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [sne_pkg::VAL_W-1:0]   value,
	output logic                               overflow
);

	import sne_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;

	// sequencer
	sne_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.sts         (sts),
		.cmd         (cmd),
		.idle        (idle)
	);

	// row store, multiplier and output register
	sne_datapath #(
		.MAX_N (MAX_N)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.row_index    (row_index),
		.column_index (column_index),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.value        (value),
		.overflow     (overflow)
	);

	assign query_stall = !idle;

endmodule

`default_nettype wire

// File: design/sne_checker.sv
`default_nettype none

`include "stirling_number_engine_macros.svh"

module sne_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          query_valid,
	input wire logic                          query_stall,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic signed [sne_pkg::VAL_W-1:0] value,
	input wire logic                          overflow
);

	// a stalled result beat stays offered
	`SNE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")

	// a stalled result beat keeps its payload
	`SNE_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(value) && $stable(overflow), "result payload changed while stalled")

	// flagged results carry a zero value
	`SNE_ASSERT_NOW(a_ovf_zero, result_valid && overflow, value == '0, "overflow result with nonzero value")

	// only one query in flight: an accepted beat makes the block busy
	`SNE_ASSERT_NEXT(a_busy_after_query, query_valid && !query_stall, query_stall, "query taken while one is in flight")

endmodule

bind stirling_number_engine sne_checker u_sne_checker (.*);

`default_nettype wire
